// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLIES_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_CLK(name, prop, msg)

`define ASSERT_IMPLIES_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/rmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared widths and sequencer state type for the running statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmsd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 16;
    localparam int SUM_W    = 40;
    localparam int SQ_W     = 63;
    localparam int MEAN_W   = 24;
    localparam int STD_W    = 23;
    localparam int ALU_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int SREM_W   = ROOT_W + 1;
    localparam int STEP_W   = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS_SAMPLE,
        ST_SQUARE,
        ST_ADD_SUM,
        ST_ADD_SQ,
        ST_ABS_SUM,
        ST_DIV_SUM,
        ST_DIV_SQ,
        ST_MEAN_SQ,
        ST_VAR,
        ST_SQRT,
        ST_MEAN
    } state_t;

endpackage

// ===== rtl/running_mean_stdev.sv =====
// ----------------------------------------------------------------------------
// running_mean_stdev
// Running count, sum, mean and population standard deviation of a sample
// stream, computed on one shared 64-bit adder under a small sequencer.
// ----------------------------------------------------------------------------
// Each transfer on the input takes one signed sample; the low SAMPLE_BITS bits
// are used, sign-extended. The block keeps a count that saturates at
// 2^COUNT_BITS - 1, a 40-bit sum and a 63-bit sum of squares, and returns one
// result per sample: count, sum, mean (truncated toward zero) and floor of the
// square root of the variance, clamped at zero. Once the count is saturated a
// sample changes nothing and count_full is set. Everything runs bit-serially
// through a single 64-bit add/subtract unit: square, two restoring divisions
// by the count, mean squared and square root. in_stall stays high from
// transfer to result. The result sits in an output register, so the next
// sample is taken while it waits. No clearing pass after reset.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module running_mean_stdev #(
    parameter int COUNT_BITS  = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rmsd_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic        [rmsd_pkg::COUNT_W-1:0]  sample_count,
    output logic signed [rmsd_pkg::SUM_W-1:0]    running_sum,
    output logic signed [rmsd_pkg::MEAN_W-1:0]   mean_value,
    output logic        [rmsd_pkg::STD_W-1:0]    std_deviation,
    output logic                                count_full
);

    localparam int ALU_W  = rmsd_pkg::ALU_W;
    localparam int SUM_W  = rmsd_pkg::SUM_W;
    localparam int SQ_W   = rmsd_pkg::SQ_W;
    localparam int ROOT_W = rmsd_pkg::ROOT_W;
    localparam int SREM_W = rmsd_pkg::SREM_W;
    localparam int STEP_W = rmsd_pkg::STEP_W;
    localparam int STD_W  = rmsd_pkg::STD_W;
    localparam int MEAN_W = rmsd_pkg::MEAN_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    rmsd_pkg::state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]         tally_reg, tally_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [SQ_W-1:0]               sq_reg, sq_next;
    logic signed [SAMPLE_BITS-1:0] samp_reg, samp_next;
    logic                          full_reg, full_next;
    logic [ALU_W-1:0]              prod_reg, prod_next;
    logic [ALU_W-1:0]              mcand_reg, mcand_next;
    logic [ALU_W-1:0]              shift_reg, shift_next;
    logic [COUNT_BITS-1:0]         rem_reg, rem_next;
    logic [SREM_W-1:0]             srem_reg, srem_next;
    logic [ROOT_W-1:0]             root_reg, root_next;
    logic [SUM_W-1:0]              qsum_reg, qsum_next;
    logic [SQ_W-1:0]               msq_reg, msq_next;
    logic [STEP_W-1:0]             step_reg, step_next;

    logic                          out_valid_reg, out_valid_next;
    logic [rmsd_pkg::COUNT_W-1:0]  count_out_reg, count_out_next;
    logic [SUM_W-1:0]              sum_out_reg, sum_out_next;
    logic [MEAN_W-1:0]             mean_out_reg, mean_out_next;
    logic [STD_W-1:0]              std_out_reg, std_out_next;
    logic                          full_out_reg, full_out_next;

    logic [ALU_W-1:0]  alu_a, alu_b;
    logic              alu_sub;
    logic [ALU_W:0]    alu_res;
    logic              alu_carry;

    logic              in_xfer;
    logic              slot_free;
    logic              last_step;
    logic [ALU_W-1:0]  samp_ext;
    logic [ALU_W-1:0]  sum_ext;
    logic [COUNT_BITS:0] div_cand;
    logic [SREM_W+1:0] sqrt_cand;
    logic [31:0]       tally_wide;
    logic [STD_W-1:0]  std_sat;
    logic [MEAN_W-1:0] mean_bits;

    assign in_stall  = (state_reg != rmsd_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign last_step = (step_reg == '0);

    assign samp_ext   = ALU_W'(samp_reg);
    assign sum_ext    = ALU_W'(signed'(sum_reg));
    assign div_cand   = {rem_reg, shift_reg[ALU_W-1]};
    assign sqrt_cand  = {srem_reg, shift_reg[ALU_W-1:ALU_W-2]};
    assign tally_wide = 32'(tally_reg);
    assign std_sat    = (|root_reg[ROOT_W-1:STD_W]) ? '1 : root_reg[STD_W-1:0];

    assign alu_res   = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}} + (ALU_W + 1)'(alu_sub);
    assign alu_carry = alu_res[ALU_W];
    assign mean_bits = sum_reg[SUM_W-1] ? alu_res[MEAN_W-1:0] : qsum_reg[MEAN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmsd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (tally_reg == COUNT_MAX) ? rmsd_pkg::ST_ABS_SUM
                                                          : rmsd_pkg::ST_ABS_SAMPLE;
                end
            end
            rmsd_pkg::ST_ABS_SAMPLE: state_next = rmsd_pkg::ST_SQUARE;
            rmsd_pkg::ST_SQUARE:
            begin
                if (last_step)
                begin
                    state_next = rmsd_pkg::ST_ADD_SUM;
                end
            end
            rmsd_pkg::ST_ADD_SUM: state_next = rmsd_pkg::ST_ADD_SQ;
            rmsd_pkg::ST_ADD_SQ:  state_next = rmsd_pkg::ST_ABS_SUM;
            rmsd_pkg::ST_ABS_SUM: state_next = rmsd_pkg::ST_DIV_SUM;
            rmsd_pkg::ST_DIV_SUM:
            begin
                if (last_step)
                begin
                    state_next = rmsd_pkg::ST_DIV_SQ;
                end
            end
            rmsd_pkg::ST_DIV_SQ:
            begin
                if (last_step)
                begin
                    state_next = rmsd_pkg::ST_MEAN_SQ;
                end
            end
            rmsd_pkg::ST_MEAN_SQ:
            begin
                if (last_step)
                begin
                    state_next = rmsd_pkg::ST_VAR;
                end
            end
            rmsd_pkg::ST_VAR: state_next = rmsd_pkg::ST_SQRT;
            rmsd_pkg::ST_SQRT:
            begin
                if (last_step)
                begin
                    state_next = rmsd_pkg::ST_MEAN;
                end
            end
            rmsd_pkg::ST_MEAN:
            begin
                if (slot_free)
                begin
                    state_next = rmsd_pkg::ST_IDLE;
                end
            end
            default: state_next = rmsd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            rmsd_pkg::ST_ABS_SAMPLE:
            begin
                alu_b   = samp_ext;
                alu_sub = 1'b1;
            end
            rmsd_pkg::ST_SQUARE, rmsd_pkg::ST_MEAN_SQ:
            begin
                alu_a = prod_reg;
                alu_b = shift_reg[0] ? mcand_reg : '0;
            end
            rmsd_pkg::ST_ADD_SUM:
            begin
                alu_a = ALU_W'(sum_reg);
                alu_b = samp_ext;
            end
            rmsd_pkg::ST_ADD_SQ:
            begin
                alu_a = ALU_W'(sq_reg);
                alu_b = prod_reg;
            end
            rmsd_pkg::ST_ABS_SUM:
            begin
                alu_b   = sum_ext;
                alu_sub = 1'b1;
            end
            rmsd_pkg::ST_DIV_SUM, rmsd_pkg::ST_DIV_SQ:
            begin
                alu_a   = ALU_W'(div_cand);
                alu_b   = ALU_W'(tally_reg);
                alu_sub = 1'b1;
            end
            rmsd_pkg::ST_VAR:
            begin
                alu_a   = ALU_W'(msq_reg);
                alu_b   = prod_reg;
                alu_sub = 1'b1;
            end
            rmsd_pkg::ST_SQRT:
            begin
                alu_a   = ALU_W'(sqrt_cand);
                alu_b   = ALU_W'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            rmsd_pkg::ST_MEAN:
            begin
                alu_b   = ALU_W'(qsum_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        tally_next     = tally_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        samp_next      = samp_reg;
        full_next      = full_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        shift_next     = shift_reg;
        rem_next       = rem_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        qsum_next      = qsum_reg;
        msq_next       = msq_reg;
        step_next      = step_reg;
        count_out_next = count_out_reg;
        sum_out_next   = sum_out_reg;
        mean_out_next  = mean_out_reg;
        std_out_next   = std_out_reg;
        full_out_next  = full_out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            rmsd_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    samp_next = sample[SAMPLE_BITS-1:0];
                    full_next = (tally_reg == COUNT_MAX);
                end
            end
            rmsd_pkg::ST_ABS_SAMPLE:
            begin
                mcand_next = samp_reg[SAMPLE_BITS-1] ? alu_res[ALU_W-1:0] : samp_ext;
                shift_next = samp_reg[SAMPLE_BITS-1] ? alu_res[ALU_W-1:0] : samp_ext;
                prod_next  = '0;
                step_next  = STEP_W'(SAMPLE_BITS - 1);
            end
            rmsd_pkg::ST_SQUARE, rmsd_pkg::ST_MEAN_SQ:
            begin
                prod_next  = alu_res[ALU_W-1:0];
                mcand_next = {mcand_reg[ALU_W-2:0], 1'b0};
                shift_next = {1'b0, shift_reg[ALU_W-1:1]};
                step_next  = step_reg - STEP_W'(1);
            end
            rmsd_pkg::ST_ADD_SUM:
            begin
                sum_next   = alu_res[SUM_W-1:0];
                tally_next = tally_reg + COUNT_BITS'(1);
            end
            rmsd_pkg::ST_ADD_SQ:
            begin
                sq_next = alu_res[SQ_W-1:0];
            end
            rmsd_pkg::ST_ABS_SUM:
            begin
                shift_next = {(sum_reg[SUM_W-1] ? alu_res[SUM_W-1:0] : sum_reg),
                              {(ALU_W - SUM_W){1'b0}}};
                rem_next   = '0;
                step_next  = STEP_W'(SUM_W - 1);
            end
            rmsd_pkg::ST_DIV_SUM, rmsd_pkg::ST_DIV_SQ:
            begin
                rem_next   = alu_carry ? alu_res[COUNT_BITS-1:0] : div_cand[COUNT_BITS-1:0];
                shift_next = {shift_reg[ALU_W-2:0], alu_carry};
                step_next  = step_reg - STEP_W'(1);
                if (last_step && state_reg == rmsd_pkg::ST_DIV_SUM)
                begin
                    qsum_next  = {shift_reg[SUM_W-2:0], alu_carry};
                    shift_next = {sq_reg, {(ALU_W - SQ_W){1'b0}}};
                    rem_next   = '0;
                    step_next  = STEP_W'(SQ_W - 1);
                end
                else if (last_step)
                begin
                    msq_next   = {shift_reg[SQ_W-2:0], alu_carry};
                    mcand_next = ALU_W'(qsum_reg);
                    shift_next = ALU_W'(qsum_reg);
                    prod_next  = '0;
                    step_next  = STEP_W'(SUM_W - 1);
                end
            end
            rmsd_pkg::ST_VAR:
            begin
                shift_next = alu_carry ? alu_res[ALU_W-1:0] : '0;
                srem_next  = '0;
                root_next  = '0;
                step_next  = STEP_W'(ROOT_W - 1);
            end
            rmsd_pkg::ST_SQRT:
            begin
                srem_next  = alu_carry ? alu_res[SREM_W-1:0] : sqrt_cand[SREM_W-1:0];
                root_next  = {root_reg[ROOT_W-2:0], alu_carry};
                shift_next = {shift_reg[ALU_W-3:0], 2'b00};
                step_next  = step_reg - STEP_W'(1);
            end
            rmsd_pkg::ST_MEAN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    count_out_next = tally_wide[rmsd_pkg::COUNT_W-1:0];
                    sum_out_next   = sum_reg;
                    mean_out_next  = mean_bits;
                    std_out_next   = std_sat;
                    full_out_next  = full_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmsd_pkg::ST_IDLE;
            tally_reg     <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg      <= samp_next;
        full_reg      <= full_next;
        prod_reg      <= prod_next;
        mcand_reg     <= mcand_next;
        shift_reg     <= shift_next;
        rem_reg       <= rem_next;
        srem_reg      <= srem_next;
        root_reg      <= root_next;
        qsum_reg      <= qsum_next;
        msq_reg       <= msq_next;
        count_out_reg <= count_out_next;
        sum_out_reg   <= sum_out_next;
        mean_out_reg  <= mean_out_next;
        std_out_reg   <= std_out_next;
        full_out_reg  <= full_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign sample_count  = count_out_reg;
    assign running_sum   = signed'(sum_out_reg);
    assign mean_value    = signed'(mean_out_reg);
    assign std_deviation = std_out_reg;
    assign count_full    = full_out_reg;

    `ASSERT_IMPLIES_NEXT(a_full_holds_state, in_xfer && tally_reg == COUNT_MAX, tally_reg == $past(tally_reg) && sum_reg == $past(sum_reg) && sq_reg == $past(sq_reg), "saturated sample changed the statistics")
    `ASSERT_IMPLIES_NEXT(a_no_result_overwrite, state_reg == rmsd_pkg::ST_MEAN && out_valid_reg && out_stall, state_reg == rmsd_pkg::ST_MEAN, "result loaded while output held")
    `ASSERT_CLK(a_sqrt_rem_bound, state_reg != rmsd_pkg::ST_SQRT || srem_reg <= {root_reg, 1'b0}, "square root remainder out of range")

endmodule

// ===== dv/running_mean_stdev_tb.sv =====
// ----------------------------------------------------------------------------
// running_mean_stdev_tb
// Drives signed fixed-point samples into the running statistics block and
// checks each result against a cycle-free model of its count, sum, mean and
// standard deviation. The phases cover directed extremes, random streams
// under sender gaps and receiver stalls, a long receiver hold-off and a full
// drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_mean_stdev_tb;

    localparam int SAMPLE_W = rmsd_pkg::SAMPLE_W;
    localparam int COUNT_W  = rmsd_pkg::COUNT_W;
    localparam int SUM_W    = rmsd_pkg::SUM_W;
    localparam int SQ_W     = rmsd_pkg::SQ_W;
    localparam int MEAN_W   = rmsd_pkg::MEAN_W;
    localparam int STD_W    = rmsd_pkg::STD_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [63:0] STD_MAX = (64'd1 << STD_W) - 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int SETTLE_CYCLES = 250;

    typedef struct {
        logic        [COUNT_W-1:0] count;
        logic signed [SUM_W-1:0]   sum;
        logic signed [MEAN_W-1:0]  mean;
        logic        [STD_W-1:0]   stdev;
        logic                      full;
    } stats_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic        [COUNT_W-1:0]  sample_count;
    logic signed [SUM_W-1:0]    running_sum;
    logic signed [MEAN_W-1:0]   mean_value;
    logic        [STD_W-1:0]    std_deviation;
    logic                       count_full;

    logic        [COUNT_W-1:0]  acc_count = '0;
    logic signed [SUM_W-1:0]    acc_sum = '0;
    logic        [SQ_W-1:0]     acc_sq = '0;

    stats_t expected_stats[$];
    stats_t oldest;
    int     error_count = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     hold_request = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    running_mean_stdev DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_count (sample_count),
        .running_sum  (running_sum),
        .mean_value   (mean_value),
        .std_deviation(std_deviation),
        .count_full   (count_full)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] radicand);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    function automatic stats_t predict_stats(input logic signed [SAMPLE_W-1:0] value);
        stats_t             r;
        logic signed [63:0] wide_val;
        logic signed [63:0] wide_sum;
        logic [63:0]        mag;
        logic [63:0]        quot;
        logic [63:0]        quot_sq;
        logic [63:0]        msq;
        logic [63:0]        var_q;
        logic [63:0]        root;
        logic               saturated;
        saturated = (acc_count >= COUNT_MAX);
        if (!saturated)
        begin
            wide_val = value;
            mag = (wide_val < 0) ? -wide_val : wide_val;
            acc_count = acc_count + 1'b1;
            acc_sum = acc_sum + value;
            acc_sq = acc_sq + SQ_W'(mag * mag);
        end
        r.mean = '0;
        r.stdev = '0;
        if (acc_count != 0)
        begin
            wide_sum = acc_sum;
            mag = (wide_sum < 0) ? -wide_sum : wide_sum;
            quot = mag / 64'(acc_count);
            quot_sq = quot * quot;
            msq = 64'(acc_sq) / 64'(acc_count);
            var_q = (msq > quot_sq) ? msq - quot_sq : 64'd0;
            r.mean = (wide_sum < 0) ? -quot[MEAN_W-1:0] : quot[MEAN_W-1:0];
            root = int_sqrt(var_q);
            r.stdev = (root > STD_MAX) ? '1 : root[STD_W-1:0];
        end
        r.count = acc_count;
        r.sum = acc_sum;
        r.full = saturated;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int                         pick;
        logic signed [SAMPLE_W-1:0] value;
        pick = $urandom_range(99);
        if (pick < 50)
            value = SAMPLE_W'($urandom());
        else if (pick < 70)
            value = SAMPLE_W'(int'($urandom_range(2047)) - 1024);
        else if (pick < 80)
            value = 24'sh7FFFFF - SAMPLE_W'($urandom_range(255));
        else if (pick < 90)
            value = -24'sh800000 + SAMPLE_W'($urandom_range(255));
        else
        begin
            case ($urandom_range(4))
                0: value = 24'sh7FFFFF;
                1: value = -24'sh800000;
                2: value = 24'sh000000;
                3: value = -24'sh000001;
                default: value = 24'sh000001;
            endcase
        end
        return value;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("count %0d %s got %h want %h",
                                      oldest.count, name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_stats.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                oldest = expected_stats.pop_front();
                check_field("sample_count", sample_count, oldest.count);
                check_field("running_sum", running_sum, oldest.sum);
                check_field("mean_value", mean_value, oldest.mean);
                check_field("std_deviation", std_deviation, oldest.stdev);
                check_field("count_full", count_full, oldest.full);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("** running_mean_stdev: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        if (send_idle_pct != 0 && $urandom_range(7) == 0)
            repeat ($urandom_range(240)) @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        sample = value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_stats.push_back(predict_stats(value));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (expected_stats.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random(input int items, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        repeat (items) send_sample(random_sample());
        wait_for_results();
    endtask

    task automatic test_directed_extremes();
        logic signed [SAMPLE_W-1:0] picks [0:19] = '{
            24'sh000000, 24'sh000001, -24'sh000001, 24'sh7FFFFF, -24'sh800000,
            24'sh7FFFFF, -24'sh800000, 24'sh000100, -24'sh000100, 24'sh000080,
            -24'sh000080, 24'sh555555, -24'sh555556, 24'sh7FFF00, -24'sh7FFF01,
            24'sh000003, 24'sh000003, 24'sh000003, 24'sh000003, 24'sh000003
        };
        send_idle_pct = 0;
        stall_pct = 0;
        foreach (picks[i])
            send_sample(picks[i]);
        wait_for_results();
    endtask

    task automatic test_streaming();
        run_random(360, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random(360, 69, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random(360, 0, 69);
    endtask

    task automatic test_mixed_idling();
        run_random(360, 18, 18);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = HOLD_OFF_CYCLES;
        @(negedge clk);
        repeat (12) send_sample(random_sample());
        wait_for_results();
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 18;
        stall_pct = 18;
        repeat (10) send_sample(random_sample());
        wait_for_results();
        repeat (10) send_sample(random_sample());
        wait_for_results();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_extremes();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_backpressure();
        test_drain_pause();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_stats.size() == 0)
            $display("** running_mean_stdev: PASSED **");
        else
            $display("** running_mean_stdev: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rmsd_pkg.sv
rtl/running_mean_stdev.sv
dv/running_mean_stdev_tb.sv
